@@ rtl/assert_macros.svh @@
// Assertion macros for the solar power mode sequencer RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("spms assertion failed");
`define SPMS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spms reset assertion failed");
`else
`define SPMS_ASSERT(lbl, clk, rstn, prop)
`define SPMS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ rtl/spms_pkg.sv @@
// Package for the solar power mode sequencer: widths, mode type,
// register indexes and reset values. No dependencies.
package spms_pkg;

  localparam int unsigned ValW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_SLEEP   = 2'd1,
    MODE_UNDERV  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_SLEEP  = 3'd0,
    CFG_SLOW_SLEEP  = 3'd1,
    CFG_SLOW_THRESH = 3'd2,
    CFG_LOCKOUT     = 3'd3,
    CFG_RECOVER     = 3'd4,
    CFG_TIMEOUT     = 3'd5
  } cfg_idx_e;

  localparam logic [ValW-1:0] FastSleepRst  = 16'd50;
  localparam logic [ValW-1:0] SlowSleepRst  = 16'd225;
  localparam logic [ValW-1:0] SlowThreshRst = 16'd7000;
  localparam logic [ValW-1:0] LockoutRst    = 16'd4000;
  localparam logic [ValW-1:0] RecoverRst    = 16'd4500;
  localparam logic [ValW-1:0] TimeoutRst    = 16'd120;
  localparam logic [ValW-1:0] CountMax      = 16'hFFFF;

endpackage

@@ rtl/solar_power_mode_sequencer_unit.sv @@
// Solar power mode sequencer: one tick per input transfer, one result per tick.
// Depends on spms_pkg and assert_macros.svh.
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o s_axis_tdata_i (tick sample)
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i m_axis_tdata_o (mode result)
// cfg       in   cfg_valid_i/cfg_ready_o         cfg_index_i, cfg_data_i
//
// One tick per cycle while ready; its result is in the output register next cycle.
// State and result are updated together at the accepting edge.
// s_axis_tready_o is high while the output register is empty or being drained.
// Reset loads the default register values, mode active, power off, counters zero.
`include "assert_macros.svh"
module solar_power_mode_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [15:0] voltage_mv, [16] shutdown_request, [17] hold_request, [23:18] zero
  input  logic [spms_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] power_on, [2:1] mode, [18:3] sleep_left, [19] hold, [23:20] zero
  output logic [spms_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [spms_pkg::ValW-1:0]      cfg_data_i
);
  import spms_pkg::*;

  logic [ValW-1:0] fast_q, slow_q, thresh_q, lockout_q, recover_q, timeout_q;
  mode_e           mode_q, mode_d;
  logic [ValW-1:0] count_q, count_d;
  logic [ValW-1:0] sleep_q, sleep_d;
  logic            hold_q, hold_d;
  logic            power_q, power_d;
  logic            ovalid_q;
  logic [OutDataW-1:0] odata_q;

  logic            s_xfer;
  logic [ValW-1:0] volt;
  logic            shut, hold_req;
  mode_e           mode_pre;
  logic            hold_pre;

  assign volt     = s_axis_tdata_i[ValW-1:0];
  assign shut     = s_axis_tdata_i[ValW];
  assign hold_req = s_axis_tdata_i[ValW+1];

  assign s_axis_tready_o = !ovalid_q || m_axis_tready_i;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // next state
  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    sleep_d  = sleep_q;
    hold_d   = hold_q;
    power_d  = power_q;
    mode_pre = MODE_ACTIVE;
    hold_pre = hold_q | hold_req;
    if (sleep_q != '0) begin
      sleep_d = sleep_q - 1'b1;
      power_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_SLEEP: mode_pre = MODE_SLEEP;
        MODE_UNDERV: mode_pre = MODE_UNDERV;
        default: mode_pre = MODE_ACTIVE;
      endcase
      if (volt < lockout_q) begin
        mode_pre = MODE_UNDERV;
      end
      if (shut && mode_pre == MODE_ACTIVE) begin
        mode_pre = MODE_SLEEP;
      end
      hold_d = hold_pre;
      mode_d = mode_pre;
      unique case (mode_pre)
        MODE_SLEEP: begin
          hold_d  = 1'b0;
          count_d = '0;
          power_d = 1'b0;
          sleep_d = (volt > thresh_q) ? fast_q : slow_q;
          mode_d  = MODE_ACTIVE;
        end
        MODE_UNDERV: begin
          if (volt > recover_q) begin
            mode_d = MODE_ACTIVE;
          end else begin
            power_d = 1'b0;
            sleep_d = fast_q;
          end
        end
        default: begin
          power_d = 1'b1;
          if (!hold_pre && count_q != CountMax) begin
            count_d = count_q + 1'b1;
          end
          if (timeout_q < count_d) begin
            mode_d = MODE_SLEEP;
          end
        end
      endcase
    end
  end

  // outputs
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ACTIVE;
      count_q  <= '0;
      sleep_q  <= '0;
      hold_q   <= 1'b0;
      power_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        mode_q   <= mode_d;
        count_q  <= count_d;
        sleep_q  <= sleep_d;
        hold_q   <= hold_d;
        power_q  <= power_d;
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      odata_q <= {{(OutDataW-ValW-4){1'b0}}, hold_d, sleep_d, mode_d, power_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q    <= FastSleepRst;
      slow_q    <= SlowSleepRst;
      thresh_q  <= SlowThreshRst;
      lockout_q <= LockoutRst;
      recover_q <= RecoverRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FAST_SLEEP:  fast_q    <= cfg_data_i;
        CFG_SLOW_SLEEP:  slow_q    <= cfg_data_i;
        CFG_SLOW_THRESH: thresh_q  <= cfg_data_i;
        CFG_LOCKOUT:     lockout_q <= cfg_data_i;
        CFG_RECOVER:     recover_q <= cfg_data_i;
        CFG_TIMEOUT:     timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `SPMS_ASSERT(a_sleep_dec, clk_i, rst_ni, s_xfer && sleep_q != '0 |=> sleep_q == $past(sleep_q) - 1'b1 && !m_axis_tdata_o[0])
  `SPMS_ASSERT(a_power_no_sleep, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[ValW+2:3] == '0)
  `SPMS_ASSERT(a_state_hold, clk_i, rst_ni, !s_xfer |=> $stable(mode_q) && $stable(sleep_q) && $stable(count_q))
  `SPMS_ASSERT(a_ready_empty, clk_i, rst_ni, !m_axis_tvalid_o |-> s_axis_tready_o)
  `SPMS_ASSERT(a_count_clear, clk_i, rst_ni, s_xfer && hold_d == 1'b0 && sleep_d != '0 && sleep_q == '0 && mode_d == MODE_ACTIVE && !power_d |=> count_q == '0 || !hold_q)

endmodule

@@ verif/tb_solar_power_mode_sequencer_unit.sv @@
// Self-checking testbench for solar_power_mode_sequencer_unit: drives tick samples and
// register writes, predicts each status word and checks it. Depends on spms_pkg.
module tb_solar_power_mode_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import spms_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam int unsigned HoldOffCycles = 60;

  typedef struct packed {
    logic [5:0]      pad;
    logic            hold_req;
    logic            shutdown;
    logic [ValW-1:0] volt;
  } tick_sample_t;

  typedef struct packed {
    logic [3:0]      pad;
    logic            hold;
    logic [ValW-1:0] sleep_left;
    mode_e           mode;
    logic            power_on;
  } status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ValW-1:0]     cfg_data_i = '0;

  solar_power_mode_sequencer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  tick_sample_t tick_backlog[$];
  status_t      status_due[$];
  int unsigned  src_idle_pct = 0;
  int unsigned  dst_idle_pct = 0;
  int unsigned  hold_off_reqs = 0;
  int unsigned  hold_off_seen = 0;
  int unsigned  hold_off_left = 0;
  logic         in_taken = 1'b0;
  int unsigned  errors = 0;
  int unsigned  ticks_taken = 0;
  int unsigned  words_checked = 0;
  int unsigned  stall_cycles = 0;

  // shadow of the register file and sequencer state
  logic [ValW-1:0] reg_shadow [6] = '{FastSleepRst, SlowSleepRst, SlowThreshRst,
                                      LockoutRst, RecoverRst, TimeoutRst};
  mode_e           mode_q = MODE_ACTIVE;
  logic [ValW-1:0] active_cnt = '0;
  logic [ValW-1:0] sleep_cnt = '0;
  logic            hold_q = 1'b0;
  logic            power_q = 1'b0;

  function automatic status_t next_status(tick_sample_t smp);
    status_t st;
    if (sleep_cnt != '0) begin
      sleep_cnt = sleep_cnt - 1'b1;
      power_q = 1'b0;
    end else begin
      if (smp.volt < reg_shadow[CFG_LOCKOUT]) mode_q = MODE_UNDERV;
      if (smp.shutdown && mode_q == MODE_ACTIVE) mode_q = MODE_SLEEP;
      if (smp.hold_req) hold_q = 1'b1;
      case (mode_q)
        MODE_ACTIVE: begin
          power_q = 1'b1;
          if (!hold_q && active_cnt != CountMax) active_cnt = active_cnt + 1'b1;
          if (reg_shadow[CFG_TIMEOUT] < active_cnt) mode_q = MODE_SLEEP;
        end
        MODE_SLEEP: begin
          hold_q = 1'b0;
          active_cnt = '0;
          power_q = 1'b0;
          sleep_cnt = (smp.volt > reg_shadow[CFG_SLOW_THRESH]) ? reg_shadow[CFG_FAST_SLEEP]
                                                               : reg_shadow[CFG_SLOW_SLEEP];
          mode_q = MODE_ACTIVE;
        end
        default: begin
          if (smp.volt > reg_shadow[CFG_RECOVER]) begin
            mode_q = MODE_ACTIVE;
          end else begin
            power_q = 1'b0;
            sleep_cnt = reg_shadow[CFG_FAST_SLEEP];
          end
        end
      endcase
    end
    st.pad = '0;
    st.hold = hold_q;
    st.sleep_left = sleep_cnt;
    st.mode = mode_q;
    st.power_on = power_q;
    return st;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    status_t want;
    status_t got;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i <= CFG_TIMEOUT)
        reg_shadow[cfg_index_i] = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        status_due.push_back(next_status(s_axis_tdata_i));
        ticks_taken++;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) stall_cycles++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (status_due.size() == 0) begin
          $display("%0t: unexpected status word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = status_due.pop_front();
          words_checked++;
          check_field("power_on", 32'(want.power_on), 32'(got.power_on));
          check_field("mode", 32'(want.mode), 32'(got.mode));
          check_field("sleep_left", 32'(want.sleep_left), 32'(got.sleep_left));
          check_field("hold", 32'(want.hold), 32'(got.hold));
          check_field("padding", 32'(want.pad), 32'(got.pad));
        end
      end
    end
  end

  // tick driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tdata_i <= tick_backlog.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // status sink, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_off_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_reqs != hold_off_seen) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HoldOffCycles;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ValW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(logic [ValW-1:0] fast, logic [ValW-1:0] slow,
                                logic [ValW-1:0] thresh, logic [ValW-1:0] lockout,
                                logic [ValW-1:0] recover, logic [ValW-1:0] timeout);
    write_reg(CFG_FAST_SLEEP, fast);
    write_reg(CFG_SLOW_SLEEP, slow);
    write_reg(CFG_SLOW_THRESH, thresh);
    write_reg(CFG_LOCKOUT, lockout);
    write_reg(CFG_RECOVER, recover);
    write_reg(CFG_TIMEOUT, timeout);
  endtask

  task automatic push_tick(logic [ValW-1:0] volt, logic shutdown, logic hold_req);
    tick_sample_t smp;
    smp.pad = '0;
    smp.volt = volt;
    smp.shutdown = shutdown;
    smp.hold_req = hold_req;
    tick_backlog.push_back(smp);
  endtask

  task automatic drain();
    while (tick_backlog.size() != 0 || s_axis_tvalid_i || status_due.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [ValW-1:0] near(logic [ValW-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[ValW-1:0];
  endfunction

  // voltages cluster around the thresholds in force
  task automatic random_ticks(int unsigned n);
    logic [ValW-1:0] volt;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: volt = '0;
        1: volt = CountMax;
        2, 3: volt = near(reg_shadow[CFG_LOCKOUT]);
        4, 5: volt = near(reg_shadow[CFG_RECOVER]);
        6: volt = near(reg_shadow[CFG_SLOW_THRESH]);
        default: volt = ValW'($urandom_range(0, 65535));
      endcase
      push_tick(volt, $urandom_range(0, 23) == 0, $urandom_range(0, 31) == 0);
    end
    drain();
  endtask

  task automatic random_settings();
    apply_settings(ValW'($urandom_range(0, 6)), ValW'($urandom_range(0, 9)),
                   ValW'($urandom_range(0, 65535)), ValW'($urandom_range(0, 40000)),
                   ValW'($urandom_range(0, 45000)), ValW'($urandom_range(0, 30)));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    src_idle_pct = 24;
    dst_idle_pct = 74;

    // reset register values, lockout boundary and hold
    push_tick(16'd5000, 1'b0, 1'b0);
    push_tick(16'd4000, 1'b0, 1'b0);
    push_tick(16'd65535, 1'b0, 1'b1);
    drain();
    write_reg(CFG_FAST_SLEEP, 16'd2);
    write_reg(CFG_SLOW_SLEEP, 16'd4);
    write_reg(CFG_TIMEOUT, 16'd3);
    // lockout, no recovery at the recover level, requests ignored during countdown
    push_tick(16'd3999, 1'b0, 1'b0);
    push_tick(16'd3999, 1'b1, 1'b1);
    push_tick(16'd0, 1'b1, 1'b1);
    push_tick(16'd4500, 1'b0, 1'b0);
    push_tick(16'd65535, 1'b1, 1'b1);
    push_tick(16'd65535, 1'b1, 1'b1);
    // recovery keeps power off for one tick, held count does not advance
    push_tick(16'd4501, 1'b0, 1'b0);
    push_tick(16'd4501, 1'b0, 1'b0);
    // shutdown above and at the slow threshold
    push_tick(16'd7001, 1'b1, 1'b0);
    push_tick(16'd0, 1'b0, 1'b0);
    push_tick(16'd0, 1'b0, 1'b0);
    push_tick(16'd7000, 1'b1, 1'b0);
    repeat (4) push_tick(16'd12345, 1'b1, 1'b1);
    // active timeout
    repeat (6) push_tick(16'd6000, 1'b0, 1'b0);
    drain();

    apply_settings(16'd3, 16'd7, 16'd6000, 16'd4000, 16'd4500, 16'd10);
    random_ticks(200);
    apply_settings('0, '0, '0, '0, '0, '0);
    random_ticks(200);

    src_idle_pct = 74;
    dst_idle_pct = 24;
    apply_settings(16'd2, 16'd5, CountMax, CountMax, CountMax, 16'd3);
    write_reg(CfgSpareLo, 16'd0);
    write_reg(CfgSpareHi, CountMax);
    random_ticks(150);
    random_settings();
    random_ticks(250);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_settings();
    hold_off_reqs++;
    random_ticks(250);
    random_settings();
    random_ticks(150);

    // full-scale registers: clear hold and count, then load a long countdown
    apply_settings('0, '0, CountMax, '0, '0, CountMax);
    repeat (10) push_tick(16'd1000, 1'b1, 1'b0);
    drain();
    write_reg(CFG_FAST_SLEEP, CountMax);
    write_reg(CFG_SLOW_SLEEP, CountMax);
    push_tick(CountMax, 1'b1, 1'b0);
    repeat (20) push_tick(16'd5000, 1'b1, 1'b1);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d ticks across reset, zero, full-scale and random register sets,",
             ticks_taken);
    $display("  %0d status words checked, %0d cycles of input stall under backpressure",
             words_checked, stall_cycles);
    if (errors == 0 && status_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d status words outstanding", status_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
